FILE: src/fp32_add_multiply_macros.svh
// Assertion macros for the single-precision add/multiply unit.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef FP32_ADD_MULTIPLY_MACROS_SVH
`define FP32_ADD_MULTIPLY_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FPAM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in any cycle implies consequent in the next.
`define FPAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/fpam_pkg.sv
// Shared types and constants for the single-precision add/multiply pipeline.
// No dependencies.
package fpam_pkg;

	localparam logic [31:0] CANON_NAN    = 32'h7F80_0001;
	localparam logic [31:0] INF_BITS     = 32'h7F80_0000;
	localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;
	localparam logic [22:0] FRAC_MASK    = 23'h7F_FFFF;
	localparam logic [7:0]  EXP_MAX      = 8'hFF;
	localparam logic [7:0]  EXP_TOP      = 8'hFE;
	localparam int          ADD_HEADROOM = 38;
	localparam int          MUL_BIAS     = 149;

	// Operation codes carried in tuser.
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_MUL = 1'b1;

	// Decoded operands after stage 1.
	typedef struct packed {
		logic        op;
		logic        sa;
		logic        sb;
		logic [23:0] ma;
		logic [23:0] mb;
		logic [7:0]  qa;
		logic [7:0]  qb;
		logic [7:0]  d;
		logic        special;
		logic [31:0] spec_bits;
	} dec_t;

	// Exact sum or product after stage 2.
	typedef struct packed {
		logic               sign;
		logic [63:0]        m;
		logic signed [10:0] q;
		logic               zero;
		logic               special;
		logic [31:0]        spec_bits;
	} exact_t;

	// Normalization data after stage 3.
	typedef struct packed {
		logic               sign;
		logic [63:0]        m;
		logic signed [11:0] s;
		logic [7:0]         base;
		logic               ovf;
		logic               zero;
		logic               special;
		logic [31:0]        spec_bits;
	} norm_t;

endpackage

FILE: src/fpam_unpack.sv
// Stage 1: operand unpacking, special-value decisions and exponent ordering.
// Depends on fpam_pkg.
module fpam_unpack import fpam_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        valid_in,
	input  logic        op,
	input  logic [31:0] a_bits,
	input  logic [31:0] b_bits,
	output logic        valid_s1,
	output dec_t        dec_s1
);

	logic [7:0]  ea, eb;
	logic [22:0] fa, fb;
	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sa, sb;
	logic [23:0] ma, mb;
	logic [7:0]  qa, qb;
	logic        swap;
	dec_t        dec;

	// Field split and classification.
	always_comb begin
		ea = a_bits[30:23];
		eb = b_bits[30:23];
		fa = a_bits[22:0] & FRAC_MASK;
		fb = b_bits[22:0] & FRAC_MASK;
		sa = a_bits[31];
		sb = b_bits[31];
		nan_a = (ea == EXP_MAX) && (fa != '0);
		nan_b = (eb == EXP_MAX) && (fb != '0);
		inf_a = (ea == EXP_MAX) && (fa == '0);
		inf_b = (eb == EXP_MAX) && (fb == '0);
		zero_a = (a_bits[30:0] == '0);
		zero_b = (b_bits[30:0] == '0);
		ma = (ea == '0) ? {1'b0, fa} : {1'b1, fa};
		mb = (eb == '0) ? {1'b0, fb} : {1'b1, fb};
		qa = (ea == '0) ? 8'd0 : ea - 8'd1;
		qb = (eb == '0) ? 8'd0 : eb - 8'd1;
		swap = (qb > qa);
	end

	// Special results and ordering of operands by exponent.
	always_comb begin
		dec.op = op;
		dec.sa = swap ? sb : sa;
		dec.sb = swap ? sa : sb;
		dec.ma = swap ? mb : ma;
		dec.mb = swap ? ma : mb;
		dec.qa = swap ? qb : qa;
		dec.qb = swap ? qa : qb;
		dec.d = swap ? (qb - qa) : (qa - qb);
		dec.special = 1'b1;
		dec.spec_bits = '0;
		if (op == OP_MUL) begin
			if (nan_a || nan_b) begin
				dec.spec_bits = CANON_NAN;
			end else if ((inf_a && zero_b) || (inf_b && zero_a)) begin
				dec.spec_bits = CANON_NAN;
			end else if (inf_a || inf_b) begin
				dec.spec_bits = INF_BITS | ((sa ^ sb) ? SIGN_BIT : '0);
			end else if (zero_a || zero_b) begin
				dec.spec_bits = (sa ^ sb) ? SIGN_BIT : '0;
			end else begin
				dec.special = 1'b0;
			end
		end else begin
			if (nan_a || nan_b) begin
				dec.spec_bits = CANON_NAN;
			end else if (inf_a && inf_b && (sa != sb)) begin
				dec.spec_bits = CANON_NAN;
			end else if (inf_a) begin
				dec.spec_bits = a_bits;
			end else if (inf_b) begin
				dec.spec_bits = b_bits;
			end else if (zero_a && zero_b) begin
				dec.spec_bits = (sa & sb) ? SIGN_BIT : '0;
			end else if (zero_a) begin
				dec.spec_bits = b_bits;
			end else if (zero_b) begin
				dec.spec_bits = a_bits;
			end else begin
				dec.special = 1'b0;
			end
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= dec;
		end
	end

endmodule

FILE: src/fpam_combine.sv
// Stage 2: mantissa alignment with add/subtract, or the significand product.
// Depends on fpam_pkg.
module fpam_combine import fpam_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   valid_s1,
	input  dec_t   dec_s1,
	output logic   valid_s2,
	output exact_t exact_s2
);

	logic [63:0] big, little, diff_bs, diff_sb;
	logic [7:0]  k;
	logic [63:0] mb_wide, mb_mask;
	exact_t      ex;

	// Alignment: the larger-exponent operand moves up by at most the headroom,
	// the smaller one moves down with a sticky bit beyond that.
	always_comb begin
		mb_wide = 64'(dec_s1.mb);
		k = dec_s1.d - 8'(ADD_HEADROOM);
		mb_mask = (64'd1 << k[4:0]) - 64'd1;
		if (dec_s1.d <= 8'(ADD_HEADROOM)) begin
			big = 64'(dec_s1.ma) << dec_s1.d[5:0];
			little = mb_wide;
		end else begin
			big = 64'(dec_s1.ma) << ADD_HEADROOM;
			if (k >= 8'd24) begin
				little = 64'd1;
			end else begin
				little = (mb_wide >> k[4:0]) | 64'((mb_wide & mb_mask) != '0);
			end
		end
		diff_bs = big - little;
		diff_sb = little - big;
	end

	// Exact result and its scale.
	always_comb begin
		ex.special = dec_s1.special;
		ex.spec_bits = dec_s1.spec_bits;
		ex.zero = 1'b0;
		if (dec_s1.op == OP_MUL) begin
			ex.sign = dec_s1.sa ^ dec_s1.sb;
			ex.m = {16'd0, 48'(dec_s1.ma) * 48'(dec_s1.mb)};
			ex.q = $signed(11'(dec_s1.qa)) + $signed(11'(dec_s1.qb)) - 11'(MUL_BIAS);
		end else begin
			ex.q = (dec_s1.d <= 8'(ADD_HEADROOM)) ? $signed(11'(dec_s1.qb))
				: $signed(11'(dec_s1.qa)) - 11'(ADD_HEADROOM);
			if (dec_s1.sa == dec_s1.sb) begin
				ex.m = big + little;
				ex.sign = dec_s1.sa;
			end else if (big > little) begin
				ex.m = diff_bs;
				ex.sign = dec_s1.sa;
			end else if (little > big) begin
				ex.m = diff_sb;
				ex.sign = dec_s1.sb;
			end else begin
				// Exact cancellation gives +0.
				ex.m = '0;
				ex.sign = 1'b0;
				ex.zero = 1'b1;
			end
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			exact_s2 <= ex;
		end
	end

endmodule

FILE: src/fpam_norm.sv
// Stage 3: leading-one search, result exponent and rounding shift amount.
// Depends on fpam_pkg.
module fpam_norm import fpam_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   valid_s2,
	input  exact_t exact_s2,
	output logic   valid_s3,
	output norm_t  norm_s3
);

	logic [5:0]         p;
	logic signed [11:0] e, qx;
	norm_t              nr;

	// Position of the leading one.
	always_comb begin
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (exact_s2.m[i]) begin
				p = 6'(i);
			end
		end
	end

	// Biased exponent, shift amount and exponent field base.
	always_comb begin
		qx = 12'(exact_s2.q);
		e = $signed(12'(p)) + qx - 12'sd22;
		nr.sign = exact_s2.sign;
		nr.m = exact_s2.m;
		nr.zero = exact_s2.zero;
		nr.special = exact_s2.special;
		nr.spec_bits = exact_s2.spec_bits;
		nr.ovf = (e >= $signed(12'(EXP_MAX)));
		if (e >= 12'sd1) begin
			nr.s = $signed(12'(p)) - 12'sd23;
			nr.base = (e > $signed(12'(EXP_TOP))) ? EXP_TOP : 8'(e - 12'sd1);
		end else begin
			nr.s = -qx;
			nr.base = '0;
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s3 <= nr;
		end
	end

endmodule

FILE: src/fpam_round.sv
// Stage 4: round to nearest even, pack, and hold the result for the output.
// Depends on fpam_pkg.
module fpam_round import fpam_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        valid_s3,
	input  norm_t       norm_s3,
	output logic        valid_s4,
	output logic [31:0] result_s4
);

	logic [5:0]  s6, s6m1, lsh;
	logic [63:0] shifted, low_mask;
	logic        guard, sticky;
	logic [24:0] r;
	logic [31:0] bits, res;

	// Shift the significand to the result grid and round.
	always_comb begin
		s6 = norm_s3.s[5:0];
		s6m1 = s6 - 6'd1;
		lsh = 6'(-norm_s3.s);
		shifted = norm_s3.m >> s6;
		low_mask = (64'd1 << s6m1) - 64'd1;
		guard = norm_s3.m[s6m1];
		sticky = (norm_s3.m & low_mask) != '0;
		if (norm_s3.s <= 12'sd0) begin
			r = 25'(norm_s3.m << lsh[4:0]);
		end else if (norm_s3.s >= 12'sd64) begin
			r = '0;
		end else begin
			r = 25'(shifted) + 25'(guard && (sticky || shifted[0]));
		end
		bits = {1'b0, norm_s3.base, 23'd0} + 32'(r);
	end

	// Final selection among special, zero, overflow and the rounded value.
	always_comb begin
		if (norm_s3.special) begin
			res = norm_s3.spec_bits;
		end else if (norm_s3.zero) begin
			res = '0;
		end else if (norm_s3.ovf || (bits >= INF_BITS)) begin
			res = (norm_s3.sign ? SIGN_BIT : '0) | INF_BITS;
		end else begin
			res = (norm_s3.sign ? SIGN_BIT : '0) | bits;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s4 <= res;
		end
	end

endmodule

FILE: src/fp32_add_multiply.sv
// IEEE-754 single-precision add/multiply unit, four register stages deep. One item
// can enter every cycle while the output is not stalled; each item passes through
// the stages unpack, align/add or multiply, leading-one search, and round, and its
// result is held in the output register until it is taken.
// The whole pipeline advances when the output register is empty or being taken,
// so s_tready follows m_tready combinationally. Rounding is to nearest, ties to even.
module fp32_add_multiply import fpam_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] a_bits, [63:32] b_bits
	input  logic        s_tuser,  // [0] action: 0 add, 1 multiply
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [31:0] result_bits
);

	logic   en;
	logic   valid_s1, valid_s2, valid_s3;
	dec_t   dec_s1;
	exact_t exact_s2;
	norm_t  norm_s3;

	// Pipeline advance.
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	fpam_unpack u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (s_tvalid),
		.op       (s_tuser),
		.a_bits   (s_tdata[31:0]),
		.b_bits   (s_tdata[63:32]),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1)
	);

	fpam_combine u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.valid_s2 (valid_s2),
		.exact_s2 (exact_s2)
	);

	fpam_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s2 (valid_s2),
		.exact_s2 (exact_s2),
		.valid_s3 (valid_s3),
		.norm_s3  (norm_s3)
	);

	fpam_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_s3  (valid_s3),
		.norm_s3   (norm_s3),
		.valid_s4  (m_tvalid),
		.result_s4 (m_tdata)
	);

endmodule

FILE: src/fpam_checker.sv
// Port-level checker for the add/multiply unit, bound to the top level.
// Depends on fp32_add_multiply_macros.svh.
`include "fp32_add_multiply_macros.svh"

module fpam_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// An empty output register never blocks the input.
	`FPAM_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")

	// Every NaN result is the canonical one.
	`FPAM_ASSERT(a_canon_nan, (m_tvalid && (m_tdata[30:23] == 8'hFF)) |-> (m_tdata[22:1] == '0), "non-canonical NaN or infinity")

	// A stalled result stays valid and unchanged.
	`FPAM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// A result that waits blocks the input.
	`FPAM_ASSERT(a_stall_blocks, (m_tvalid && !m_tready) |-> !s_tready, "input taken while output stalled")

endmodule

bind fp32_add_multiply fpam_checker u_fpam_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
